// File: hdl/cpfm_pkg.sv
// Shared constants for the capture pair frequency meter.
package cpfm_pkg;

  localparam int RATE_W         = 40;
  localparam int STAMP_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_W          = 40;
  localparam int DIV_CNT_W      = $clog2(RATE_W);

  // 168 MHz / 2564 in Q.8, rounded
  localparam logic [RATE_W-1:0] RATE_RESET = 40'd16773791;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 2'd1;

endpackage

// File: hdl/capture_pair_frequency_meter_core.sv
// Capture pair frequency meter: pairs timestamps, forms the tick period, divides the rate.
// Sequence after the second word of a pair: period calc, 40 restoring-divide steps,
//   load to output register; equal stamps skip the divide steps.
// Input: a first word is taken without a stall; a second word blocks input until its result
//   is loaded (out_stall can delay that), as the single bit-serial subtract/compare unit serves one pair at a time.
// Reset (rst_n low, synchronous): disarmed, idle, no result, rate 168e6/2564 Hz Q.8, top all ones.
module capture_pair_frequency_meter_core #(
  parameter int STAMP_BITS = cpfm_pkg::STAMP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config write port
  input  logic                          cfg_wr_en,
  input  logic [cpfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cpfm_pkg::CFG_W-1:0]    cfg_wdata,
  // capture words in
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [STAMP_BITS-1:0]         in_capture_stamp,
  // measurement words out
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cpfm_pkg::RATE_W-1:0]   out_frequency_q8,
  output logic [STAMP_BITS:0]           out_period_ticks,
  output logic                          out_equal_stamps_error
);

  localparam int RW = cpfm_pkg::RATE_W;
  localparam int PW = STAMP_BITS + 1;   // period width
  localparam int CW = cpfm_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] LAST_BIT = CW'(RW - 1);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;

  // configuration
  logic [RW-1:0]         rate_r;
  logic [STAMP_BITS-1:0] top_r;

  // pairing state
  logic                  armed_r;
  logic [STAMP_BITS-1:0] first_r;
  logic [STAMP_BITS-1:0] second_r;

  // divider datapath
  logic [PW-1:0]         period_r, period_nxt;
  logic [PW-1:0]         rem_r, rem_nxt;
  logic [RW-1:0]         dq_r, dq_nxt;       // dividend shifts out, quotient shifts in
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  err_r, err_nxt;

  // output register
  logic                  out_valid_r;
  logic [RW-1:0]         out_freq_r;
  logic [PW-1:0]         out_period_r;
  logic                  out_err_r;

  logic                  in_acc;
  logic                  out_load;
  logic [PW-1:0]         period_calc;
  logic [PW:0]           trial;
  logic                  trial_ge;

  // Only the idle sequencer takes a word; a first capture just arms.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Output register frees up when empty or being taken this cycle.
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Tick difference; the wrap case is taken modulo 2^PW.
  always_comb begin
    unique if (second_r > first_r) begin
      period_calc = {1'b0, second_r} - {1'b0, first_r};
    end else if (second_r < first_r) begin
      period_calc = {1'b0, top_r} - {1'b0, first_r} + {1'b0, second_r} + PW'(1);
    end else begin
      period_calc = '0;
    end
  end

  // Shared restoring-divide step: one compare/subtract per cycle.
  assign trial    = {rem_r, dq_r[RW-1]};
  assign trial_ge = (trial >= {1'b0, period_r});

  always_comb begin
    state_nxt  = state_r;
    period_nxt = period_r;
    rem_nxt    = rem_r;
    dq_nxt     = dq_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && armed_r) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        period_nxt = period_calc;
        rem_nxt    = '0;
        dq_nxt     = rate_r;
        cnt_nxt    = '0;
        err_nxt    = (period_calc == '0);
        state_nxt  = (period_calc == '0) ? ST_DONE : ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = trial_ge ? PW'(trial - {1'b0, period_r}) : PW'(trial);
        dq_nxt  = {dq_r[RW-2:0], trial_ge};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_BIT) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rate_r      <= cpfm_pkg::RATE_RESET;
      top_r       <= '1;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        armed_r <= !armed_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          cpfm_pkg::CFG_RATE: rate_r <= cfg_wdata[RW-1:0];
          cpfm_pkg::CFG_TOP:  top_r  <= cfg_wdata[STAMP_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (armed_r) begin
        second_r <= in_capture_stamp;
      end else begin
        first_r <= in_capture_stamp;
      end
    end
    period_r <= period_nxt;
    rem_r    <= rem_nxt;
    dq_r     <= dq_nxt;
    cnt_r    <= cnt_nxt;
    err_r    <= err_nxt;
    if (out_load) begin
      out_freq_r   <= err_r ? '0 : dq_r;
      out_period_r <= err_r ? '0 : period_r;
      out_err_r    <= err_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_frequency_q8       = out_freq_r;
  assign out_period_ticks       = out_period_r;
  assign out_equal_stamps_error = out_err_r;

`ifndef SYNTHESIS
  // error results carry zero frequency and period
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_freq_r == '0 && out_period_r == '0))
    else $error("error result with nonzero payload");

  // a good result never has a zero period
  a_period_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_err_r) |-> (out_period_r != '0))
    else $error("zero period without error flag");

  // divide step count stays in range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= LAST_BIT))
    else $error("divide counter overran");

  // nonzero period always goes through the divider
  a_calc_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC && period_calc != '0) |=> (state_r == ST_DIV))
    else $error("divider skipped");

  // a second capture starts the sequencer
  a_pair_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && armed_r) |=> (state_r == ST_CALC && !armed_r))
    else $error("second capture did not start a measurement");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the capture pair frequency meter core.
module tb;

  localparam int SW          = cpfm_pkg::STAMP_BITS_DEF;
  localparam int RW          = cpfm_pkg::RATE_W;
  localparam int CFGW        = cpfm_pkg::CFG_W;
  localparam int IDXW        = cpfm_pkg::CFG_IDX_W;
  localparam int CYCLE_LIMIT = 1_000_000;
  // extra wait after the last owed result, as margin
  localparam int SETTLE      = 60;
  localparam int PHASE_WORDS = 148;
  localparam logic [RW-1:0] RATE_MAX = {RW{1'b1}};
  localparam logic [SW-1:0] TOP_MAX  = {SW{1'b1}};

  typedef struct packed {
    logic [RW-1:0] freq;
    logic [SW:0]   period;
    logic          err;
  } meas_t;

  logic                 clk              = 1'b0;
  logic                 rst_n            = 1'b0;
  logic                 cfg_wr_en        = 1'b0;
  logic [IDXW-1:0]      cfg_index        = cpfm_pkg::CFG_RATE;
  logic [CFGW-1:0]      cfg_wdata        = '0;
  logic                 in_valid         = 1'b0;
  logic                 in_stall;
  logic [SW-1:0]        in_capture_stamp = '0;
  logic                 out_valid;
  logic                 out_stall        = 1'b0;
  logic [RW-1:0]        out_frequency_q8;
  logic [SW:0]          out_period_ticks;
  logic                 out_equal_stamps_error;

  // Predictor state: register copies plus the pairing state.
  logic [RW-1:0]     rate_q  = cpfm_pkg::RATE_RESET;
  logic [SW-1:0]     top_q   = TOP_MAX;
  logic              armed_q = 1'b0;
  logic [SW-1:0]     first_q = '0;
  meas_t             meas_q[$];   // measurements still owed by the block

  bit idle_on = 1'b1;             // random gaps / stalls enabled
  int n_stamps, n_meas, n_err_meas, n_settings, n_fail, cycles;

  capture_pair_frequency_meter_core u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_capture_stamp       (in_capture_stamp),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_frequency_q8       (out_frequency_q8),
    .out_period_ticks       (out_period_ticks),
    .out_equal_stamps_error (out_equal_stamps_error)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs or drops a handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d measurements outstanding",
               cycles, meas_q.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Mostly short idles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Pairing and divide, at the block's widths. The wrap branch is a 17-bit
  // subtractor, so stamps above top wrap modulo 2^17 like the hardware.
  task automatic predict_capture(input logic [SW-1:0] stamp);
    logic [SW:0] span;
    meas_t       m;
    if (!armed_q) begin
      first_q = stamp;
      armed_q = 1'b1;
      return;
    end
    armed_q = 1'b0;
    if (stamp > first_q)
      span = {1'b0, stamp} - {1'b0, first_q};
    else if (stamp < first_q)
      span = {1'b0, top_q} - {1'b0, first_q} + {1'b0, stamp} + 1'b1;
    else
      span = '0;
    if (span == '0) begin
      m.freq   = '0;
      m.period = '0;
      m.err    = 1'b1;
    end else begin
      m.freq   = rate_q / span;
      m.period = span;
      m.err    = 1'b0;
    end
    meas_q.push_back(m);
  endtask

  // One capture word. Valid is only dropped when a gap actually follows, so it
  // never gets two updates in the same step.
  task automatic send_stamp(input logic [SW-1:0] stamp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_capture_stamp <= stamp;
    do @(posedge clk); while (in_stall);
    predict_capture(stamp);
    n_stamps++;
  endtask

  task automatic send_pair(input logic [SW-1:0] a, input logic [SW-1:0] b);
    send_stamp(a);
    send_stamp(b);
  endtask

  // Park the input and wait until every owed measurement is back, then let a
  // pending first word settle before anything else touches the block.
  task automatic await_idle();
    in_valid <= 1'b0;
    while (meas_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers, back to back; wr_en stays high across both writes.
  task automatic set_config(input logic [RW-1:0] rate, input logic [SW-1:0] top);
    await_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= cpfm_pkg::CFG_RATE;
    cfg_wdata <= rate;
    @(posedge clk);
    rate_q    = rate;
    cfg_index <= cpfm_pkg::CFG_TOP;
    cfg_wdata <= CFGW'(top);
    @(posedge clk);
    top_q     = top;
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // Mostly well-formed pairs inside [0, top]; some equal pairs, some stamps
  // above top, and stray single words that shift the pairing.
  task automatic send_random_pair();
    logic [SW-1:0] a, b;
    int            kind, ai, d;
    kind = $urandom_range(0, 99);
    a    = SW'($urandom_range(0, top_q));
    ai   = a;
    if (kind < 50) begin
      b = SW'($urandom_range(0, top_q));
      send_pair(a, b);
    end else if (kind < 75) begin
      d = $urandom_range(1, 64);
      b = SW'((ai + d) % (int'(top_q) + 1));
      send_pair(a, b);
    end else if (kind < 85) begin
      send_pair(a, a);
    end else if (kind < 95) begin
      send_pair(SW'($urandom), SW'($urandom));
    end else begin
      send_stamp(SW'($urandom));
    end
  endtask

  // Checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_meas
    meas_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (meas_q.size() == 0) begin
        $error("unexpected word: frequency_q8 %0d period_ticks %0d error %0b",
               out_frequency_q8, out_period_ticks, out_equal_stamps_error);
        n_fail++;
      end else begin
        want = meas_q.pop_front();
        n_meas++;
        if (want.err) n_err_meas++;
        if (out_frequency_q8 !== want.freq) begin
          $error("frequency_q8: expected %0d, got %0d", want.freq, out_frequency_q8);
          n_fail++;
        end
        if (out_period_ticks !== want.period) begin
          $error("period_ticks: expected %0d, got %0d", want.period, out_period_ticks);
          n_fail++;
        end
        if (out_equal_stamps_error !== want.err) begin
          $error("equal_stamps_error: expected %0b, got %0b",
                 want.err, out_equal_stamps_error);
          n_fail++;
        end
      end
    end
  end

  // Receiver stalls: runs of random length, off entirely when idling is off.
  initial begin : stall_gen
    int len;
    forever begin
      @(posedge clk);
      out_stall <= idle_on && ($urandom_range(0, 2) == 0);
      len = pick_gap();
      repeat (len) @(posedge clk);
    end
  end

  // Reset values: plain pair, wrapped pair, equal pair, full-scale spans.
  task automatic test_reset_settings();
    send_pair(16'd100, 16'd1100);
    send_pair(16'd65000, 16'd500);
    send_pair(16'd7, 16'd7);
    send_pair(16'd0, TOP_MAX);
    send_pair(TOP_MAX, 16'd0);
  endtask

  // Register extremes, stamps beyond top, a wrap that cancels to zero,
  // zero rate and a counter whose top is 1.
  task automatic test_register_extremes();
    set_config(RATE_MAX, 16'd1000);
    send_pair(16'd900, 16'd100);
    send_pair(16'd2000, 16'd5);      // first stamp above top
    send_pair(16'd1500, 16'd499);    // wrapped span is zero -> error word
    set_config('0, TOP_MAX);
    send_pair(16'd1, 16'd2);         // zero rate, no error
    set_config(40'd1, 16'd1);
    send_pair(16'd1, 16'd0);
    send_pair(16'd0, 16'd1);
    send_pair(16'd0, TOP_MAX);
  endtask

  // Sender holds off mid-stream until the block has returned everything.
  task automatic test_backlog_drain();
    repeat (10) send_random_pair();
    await_idle();
    repeat (10) send_random_pair();
  endtask

  // Random traffic over several register settings.
  task automatic test_random_traffic();
    logic [RW-1:0] rate;
    logic [SW-1:0] top;
    int            target;
    for (int p = 0; p < 6; p++) begin
      rate = RW'({$urandom, $urandom});
      top  = SW'($urandom_range(1, TOP_MAX));
      unique case (p)
        0: top = TOP_MAX;
        1: rate = RATE_MAX;
        2: begin
          rate = RW'($urandom_range(1, 255));
          top  = SW'($urandom_range(1, 16));
        end
        4: begin
          rate = 40'd1;
          top  = TOP_MAX;
        end
        default: ;
      endcase
      if (rate == '0) rate = 40'd1;
      set_config(rate, top);
      idle_on = (p != 3);            // one setting runs with no idling at all
      target  = n_stamps + PHASE_WORDS;
      while (n_stamps < target) send_random_pair();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_register_extremes();
    test_backlog_drain();
    test_random_traffic();

    await_idle();
    $display("run: %0d capture words in, %0d measurements checked (%0d equal-stamp)",
             n_stamps, n_meas, n_err_meas);
    $display("run: %0d register settings besides reset, %0d cycles", n_settings, cycles);
    if (n_fail == 0 && meas_q.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/cpfm_pkg.sv
hdl/capture_pair_frequency_meter_core.sv
tb/tb.sv
